// ----- rtl/core/itp_pkg.sv -----
// itp_pkg: shared types and symbol constants for the infix-to-prefix converter.
// No dependencies.
package itp_pkg;

  localparam logic [7:0] SymCaret  = 8'h5E;
  localparam logic [7:0] SymStar   = 8'h2A;
  localparam logic [7:0] SymSlash  = 8'h2F;
  localparam logic [7:0] SymPlus   = 8'h2B;
  localparam logic [7:0] SymMinus  = 8'h2D;
  localparam logic [7:0] SymLParen = 8'h28;
  localparam logic [7:0] SymRParen = 8'h29;

  // entry handed from front to back
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       keep;   // byte fits in the buffer
  } itp_entry_t;

  // FETCH reads the buffer, SCAN classifies, POP/POPF reload the stack top
  typedef enum logic [3:0] {
    ST_LOAD, ST_FETCH, ST_SCAN, ST_POP, ST_POPF, ST_DRAIN, ST_READ, ST_EMIT, ST_EMPTY
  } itp_state_t;

  function automatic logic is_op(input logic [7:0] c);
    return c == SymCaret || c == SymStar || c == SymSlash ||
           c == SymPlus || c == SymMinus;
  endfunction

  function automatic logic binds_tighter(input logic [7:0] top, input logic [7:0] cur);
    logic lo;
    lo = (cur == SymPlus) || (cur == SymMinus);
    if (top == SymCaret) return lo || cur == SymStar || cur == SymSlash;
    if (top == SymStar || top == SymSlash) return lo;
    return 1'b0;
  endfunction

endpackage

// ----- rtl/core/itp_front.sv -----
// itp_front: accepts input beats, tracks buffer fill, queues entries.
// Depends on itp_pkg.
module itp_front #(
  parameter int MAX_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        symbol,
  input  logic              last,
  input  logic              in_valid,
  output logic              in_ready,
  output itp_pkg::itp_entry_t q_data,
  output logic              q_valid,
  input  logic              q_ready
);
  localparam int CW = $clog2(MAX_LEN + 1);
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic          busy;   // a run is in the back part

  // one-entry queue
  always_comb in_ready = !q_valid && !busy;

  always_comb begin
    fill_next = fill;
    if (in_valid && in_ready) begin
      if (last) fill_next = '0;
      else if (fill < CW'(MAX_LEN)) fill_next = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      q_valid <= 1'b0;
      busy <= 1'b0;
    end else begin
      fill <= fill_next;
      if (in_valid && in_ready) begin
        q_valid <= 1'b1;
        q_data.symbol <= symbol;
        q_data.last <= last;
        q_data.keep <= fill < CW'(MAX_LEN);
        if (last) busy <= 1'b1;
      end else if (q_ready) begin
        q_valid <= 1'b0;
      end
      // busy clears once the back is loading again and the queue is empty
      if (busy && q_ready && !q_valid) busy <= 1'b0;
    end
  end
endmodule

// ----- rtl/core/itp_back.sv -----
// itp_back: buffers the expression, runs the stack scan, emits the prefix.
// Depends on itp_pkg.
module itp_back #(
  parameter int MAX_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  itp_pkg::itp_entry_t q_data,
  input  logic              q_valid,
  output logic              q_ready,
  output logic [7:0]        o_symbol,
  output logic              o_end,
  output logic              o_empty,
  output logic              o_ovf,
  output logic              o_valid,
  input  logic              o_ready
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = $clog2(MAX_LEN + 2);

  logic [7:0] ibuf [MAX_LEN];
  logic [7:0] rbuf [MAX_LEN];
  logic [7:0] stk  [MAX_LEN+1];

  itp_pkg::itp_state_t state, state_next;
  logic [CW-1:0] icnt, pos, rcnt, k;
  logic [SW-1:0] sp;
  logic          ovf;
  logic          fin;    // start of text reached: only the final pop remains
  logic [7:0]    c, top, rd, cur;

  logic out_free, fire_out;
  logic room, pre_room, tighter, lp_pop;
  logic push_en, pop_en, pre_en;
  logic [7:0] push_val, pre_val;

  always_comb out_free = !o_valid || o_ready;
  always_comb q_ready = (state == itp_pkg::ST_LOAD);

  // at the start of text the scan behaves as if it read a '('
  always_comb cur = fin ? itp_pkg::SymLParen : c;

  always_comb begin
    room     = sp < SW'(MAX_LEN + 1);
    pre_room = rcnt < CW'(MAX_LEN);
    tighter  = (sp != '0) && itp_pkg::binds_tighter(top, cur);
    lp_pop   = (sp != '0) && (top != itp_pkg::SymRParen);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itp_pkg::ST_LOAD:  if (q_valid && q_data.last) state_next = itp_pkg::ST_FETCH;
      itp_pkg::ST_FETCH: state_next = (sp == '0) ? itp_pkg::ST_DRAIN : itp_pkg::ST_SCAN;
      itp_pkg::ST_SCAN: begin
        if (cur == itp_pkg::SymRParen) state_next = itp_pkg::ST_FETCH;
        else if (itp_pkg::is_op(cur)) begin
          state_next = tighter ? itp_pkg::ST_POP : itp_pkg::ST_FETCH;
        end else if (cur == itp_pkg::SymLParen) begin
          if (lp_pop) state_next = itp_pkg::ST_POP;
          else if (fin) state_next = itp_pkg::ST_DRAIN;
          else state_next = itp_pkg::ST_POPF;
        end else state_next = itp_pkg::ST_FETCH;
      end
      itp_pkg::ST_POP:   state_next = itp_pkg::ST_SCAN;
      itp_pkg::ST_POPF:  state_next = itp_pkg::ST_FETCH;
      itp_pkg::ST_DRAIN: state_next = (rcnt == '0) ? itp_pkg::ST_EMPTY : itp_pkg::ST_READ;
      itp_pkg::ST_READ:  state_next = itp_pkg::ST_EMIT;
      itp_pkg::ST_EMIT: begin
        if (out_free) state_next = (k == CW'(1)) ? itp_pkg::ST_LOAD : itp_pkg::ST_READ;
      end
      itp_pkg::ST_EMPTY: if (out_free) state_next = itp_pkg::ST_LOAD;
      default:           state_next = itp_pkg::ST_LOAD;
    endcase
  end

  // per-state actions
  always_comb begin
    push_en  = 1'b0;
    push_val = itp_pkg::SymRParen;
    pop_en   = 1'b0;
    pre_en   = 1'b0;
    pre_val  = cur;
    fire_out = 1'b0;
    unique case (state)
      itp_pkg::ST_LOAD: push_en = q_valid && q_data.last;   // bottom marker
      itp_pkg::ST_SCAN: begin
        if (cur == itp_pkg::SymRParen) begin
          push_en = room;
        end else if (itp_pkg::is_op(cur)) begin
          if (tighter) begin
            pre_en = pre_room; pre_val = top; pop_en = 1'b1;
          end else begin
            push_en = room; push_val = cur;
          end
        end else if (cur == itp_pkg::SymLParen) begin
          if (lp_pop) begin
            pre_en = pre_room; pre_val = top; pop_en = 1'b1;
          end else begin
            pop_en = (sp != '0);   // drop the matching ')'
          end
        end else begin
          pre_en = pre_room;       // operand
        end
      end
      itp_pkg::ST_EMIT:  fire_out = out_free;
      itp_pkg::ST_EMPTY: fire_out = out_free;
      default:           fire_out = 1'b0;
    endcase
  end

  // buffers and stack; top mirrors stk[sp-1]
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_data.keep) ibuf[icnt[AW-1:0]] <= q_data.symbol;
    if (state == itp_pkg::ST_FETCH) c <= ibuf[AW'(pos - 1'b1)];
    if (push_en) stk[sp] <= push_val;
    if (push_en) top <= push_val;
    else if ((state == itp_pkg::ST_POP || state == itp_pkg::ST_POPF) && sp != '0)
      top <= stk[sp - 1'b1];
    if (pre_en) rbuf[rcnt[AW-1:0]] <= pre_val;
    if (state == itp_pkg::ST_READ) rd <= rbuf[AW'(k - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= itp_pkg::ST_LOAD;
      icnt    <= '0;
      pos     <= '0;
      rcnt    <= '0;
      k       <= '0;
      sp      <= '0;
      ovf     <= 1'b0;
      fin     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire_out) o_valid <= 1'b1;
      else if (o_ready) o_valid <= 1'b0;
      if (state == itp_pkg::ST_LOAD && q_valid) begin
        if (q_data.keep) icnt <= icnt + 1'b1;
        else ovf <= 1'b1;
        if (q_data.last) begin
          pos  <= q_data.keep ? icnt + 1'b1 : icnt;
          sp   <= SW'(1);
          rcnt <= '0;
          fin  <= 1'b0;
        end
      end
      if (state == itp_pkg::ST_FETCH && sp != '0) begin
        if (pos == '0) fin <= 1'b1;
        else pos <= pos - 1'b1;
      end
      if (state == itp_pkg::ST_SCAN) begin
        if (push_en) sp <= sp + 1'b1;
        else if (pop_en) sp <= sp - 1'b1;
        if (pre_en) rcnt <= rcnt + 1'b1;
      end
      if (state == itp_pkg::ST_DRAIN) k <= rcnt;
      if (fire_out) begin
        o_symbol <= (state == itp_pkg::ST_EMPTY) ? 8'h00 : rd;
        o_end    <= (state == itp_pkg::ST_EMPTY) || (k == CW'(1));
        o_empty  <= (state == itp_pkg::ST_EMPTY);
        o_ovf    <= ovf;
        if (state == itp_pkg::ST_EMPTY || k == CW'(1)) begin
          icnt <= '0; pos <= '0; rcnt <= '0; sp <= '0; ovf <= 1'b0; fin <= 1'b0;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  a_sp: assert property (@(posedge clk) disable iff (rst) sp <= SW'(MAX_LEN + 1))
    else $error("stack pointer out of range");
  a_rc: assert property (@(posedge clk) disable iff (rst) rcnt <= CW'(MAX_LEN))
    else $error("result count out of range");
  a_ic: assert property (@(posedge clk) disable iff (rst) icnt <= CW'(MAX_LEN))
    else $error("input count out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_ready) |=> o_valid && $stable(o_symbol) && $stable(o_end) &&
                              $stable(o_empty) && $stable(o_ovf))
    else $error("output beat changed while stalled");
endmodule

// ----- rtl/core/infix_to_prefix_converter.sv -----
// infix_to_prefix_converter: top level joining the front and back parts.
// Depends on itp_pkg, itp_front, itp_back.
//
// Usage: send an infix expression on s_axis one byte per beat, tdata = symbol,
// tlast on the final byte. Bytes beyond MAX_LEN are dropped and flagged.
// After the last beat the back part scans the buffer from its end with an
// operator stack, then streams the prefix text on m_axis, one byte per beat,
// tlast on the final byte. tuser = {overflow, empty_res}; an empty result is
// a single beat with tdata 0 and empty_res set.
// The one-entry queue takes a new input beat only once the back part has
// taken the previous one. Once the back takes the last byte, the scan reads
// each byte from the buffer and classifies it, reloads the registered stack
// top after each stack pop and treats the start of the text as a '('; the
// output then starts and each result byte is read from the result buffer and
// registered on the output while m_axis_tready is high.
// s_axis stays stalled from the last beat until the final result is registered.
// Reset (rst, synchronous) clears counters and flags; buffers keep junk.
// When m_axis_tready is low the output beat holds and the back part waits.
module infix_to_prefix_converter #(
  parameter int MAX_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] symbol_out
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser,   // [0] empty_res, [1] overflow
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready
);
  itp_pkg::itp_entry_t q_data;
  logic q_valid, q_ready;

  itp_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst, .symbol(s_axis_tdata), .last(s_axis_tlast),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .q_data, .q_valid, .q_ready
  );

  itp_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst, .q_data, .q_valid, .q_ready,
    .o_symbol(m_axis_tdata), .o_end(m_axis_tlast),
    .o_empty(m_axis_tuser[0]), .o_ovf(m_axis_tuser[1]),
    .o_valid(m_axis_tvalid), .o_ready(m_axis_tready)
  );
endmodule
